// ===== hdl/lu_linear_solver_core_assert.svh =====
// Assertion macros used by the solver core RTL.
`ifndef LU_LINEAR_SOLVER_CORE_ASSERT_SVH
`define LU_LINEAR_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lu_pkg.sv =====
// Package with Q16.16 constants and the saturation helper for the solver.
`default_nettype none
package lu_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam int QUOT_BITS = 48;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(Q_MAX)) begin
      r = Q_MAX;
    end else if (v < 64'(Q_MIN)) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/lu_linear_solver_core.sv =====
// Loads up to ORDER*(ORDER+1) words, then elimination and back substitution.
// Division waits on done; multiply-update walks S_J_RD1, S_J_RD2, S_J_MUL, S_J_UPD.
// Throughput: one matrix at a time; in_stall stays high from the last word
// until the final result word has been taken.
// Reset (rst_n, synchronous, active low) clears the sequencer and load count.
// The matrix memory needs no clearing pass.
`default_nettype none
module lu_linear_solver_core import lu_pkg::*; #(
  parameter int ORDER = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic               in_last_element,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_row_index,
  output logic signed [31:0]      out_solution_value,
  output logic signed [31:0]      out_intermediate_value,
  output logic                    out_singular_flag,
  output logic                    out_last_result
);
`include "lu_linear_solver_core_assert.svh"

  localparam int COLS  = ORDER + 1;
  localparam int CELLS = ORDER * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int LCW   = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLS + 1);
  localparam int XW    = $clog2(ORDER);

  // The sequencer walks load, elimination, back substitution and result output.
  // Each memory read is used in the next state or in the same state's next pass.
  typedef enum logic [15:0] {
    S_LOAD  = 16'h0001,
    S_K_RD  = 16'h0002,
    S_K_CHK = 16'h0004,
    S_I_RD  = 16'h0008,
    S_I_DIV = 16'h0010,
    S_I_WT  = 16'h0020,
    S_J_RD1 = 16'h0040,
    S_J_RD2 = 16'h0080,
    S_J_MUL = 16'h0100,
    S_J_UPD = 16'h0200,
    S_B_RD  = 16'h0400,
    S_B_CHK = 16'h0800,
    S_B_JRD = 16'h1000,
    S_B_MUL = 16'h2000,
    S_B_ACC = 16'h4000,
    S_B_YRD = 16'h8000
  } state_t;

  typedef enum logic [2:0] {
    P_NONE = 3'b001,
    P_DIV  = 3'b010,
    P_OUT  = 3'b100
  } phase_t;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [CW-1:0]         k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [LCW-1:0]        lcnt_r, lcnt_nxt;
  logic                  sing_r, sing_nxt;
  logic signed [31:0]    piv_r, piv_nxt;
  logic signed [31:0]    m_r, m_nxt;
  logic signed [31:0]    akj_r, akj_nxt;
  logic signed [31:0]    aij_r, aij_nxt;
  logic signed [63:0]    prod_r, prod_nxt;
  logic signed [52:0]    sum_r, sum_nxt;
  logic signed [31:0]    x_r [ORDER];
  logic                  x_we;
  logic signed [31:0]    mem [CELLS];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic signed [31:0]    mem_wd;
  logic signed [31:0]    rd_data_r;
  logic                  div_start, div_done;
  logic signed [31:0]    div_num, div_quot;
  logic                  out_go;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * COLS + int'(c));
  endfunction

  lu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (piv_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_stall  = !(phase_r == P_NONE && state_r == S_LOAD);
  assign out_valid = (phase_r == P_OUT) && state_r == S_LOAD;
  assign out_go    = out_valid && !out_stall;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lcnt_nxt  = lcnt_r;
    sing_nxt  = sing_r;
    piv_nxt   = piv_r;
    m_nxt     = m_r;
    akj_nxt   = akj_r;
    aij_nxt   = aij_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    mem_we    = 1'b0;
    mem_wa    = addr(i_r, j_r);
    mem_wd    = sat32(64'(aij_r) - (prod_r >>> FRAC_BITS));
    mem_ra    = addr(i_r, CW'(ORDER));
    div_start = 1'b0;
    div_num   = rd_data_r;
    x_we      = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (phase_r == P_OUT) begin
          // Result words: i_r names the unknown, rd_data_r holds its y.
          mem_ra = addr(i_r, CW'(ORDER));
          if (out_go) begin
            if (i_r == CW'(ORDER - 1)) begin
              phase_nxt = P_NONE;
            end else begin
              i_nxt     = i_r + 1'b1;
              mem_ra    = addr(i_r + 1'b1, CW'(ORDER));
            end
          end
        end else if (in_valid) begin
          mem_wa = lcnt_r[AW-1:0];
          mem_wd = in_element_value;
          if (lcnt_r < LCW'(CELLS)) begin
            mem_we   = 1'b1;
            lcnt_nxt = lcnt_r + 1'b1;
          end
          if (in_last_element) begin
            lcnt_nxt  = '0;
            sing_nxt  = 1'b0;
            k_nxt     = '0;
            phase_nxt = P_DIV;
            state_nxt = S_K_RD;
          end
        end
      end
      S_K_RD: begin
        mem_ra    = addr(k_r, k_r);
        state_nxt = S_K_CHK;
      end
      S_K_CHK: begin
        piv_nxt = rd_data_r;
        if (rd_data_r == 32'sd0) begin
          sing_nxt  = 1'b1;
          i_nxt     = '0;
          mem_ra    = addr('0, CW'(ORDER));
          phase_nxt = P_OUT;
          state_nxt = S_LOAD;
        end else begin
          i_nxt     = k_r + 1'b1;
          state_nxt = S_I_RD;
        end
      end
      S_I_RD: begin
        mem_ra    = addr(i_r, k_r);
        state_nxt = S_I_DIV;
      end
      S_I_DIV: begin
        div_start = 1'b1;
        state_nxt = S_I_WT;
      end
      S_I_WT: begin
        if (div_done) begin
          // The entry below the pivot is eliminated and stored as zero.
          mem_we    = 1'b1;
          mem_wa    = addr(i_r, k_r);
          mem_wd    = '0;
          m_nxt     = div_quot;
          j_nxt     = k_r + 1'b1;
          state_nxt = S_J_RD1;
        end
      end
      S_J_RD1: begin
        mem_ra    = addr(k_r, j_r);
        state_nxt = S_J_RD2;
      end
      S_J_RD2: begin
        akj_nxt   = rd_data_r;
        mem_ra    = addr(i_r, j_r);
        state_nxt = S_J_MUL;
      end
      S_J_MUL: begin
        aij_nxt   = rd_data_r;
        prod_nxt  = 64'(m_r) * 64'(akj_r);
        state_nxt = S_J_UPD;
      end
      S_J_UPD: begin
        // Floor of the product comes from the arithmetic shift.
        mem_we = 1'b1;
        if (j_r == CW'(COLS - 1)) begin
          if (i_r == CW'(ORDER - 1)) begin
            if (k_r == CW'(ORDER - 2)) begin
              i_nxt     = CW'(ORDER - 1);
              state_nxt = S_B_RD;
            end else begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_K_RD;
            end
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_I_RD;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_J_RD1;
        end
      end
      S_B_RD: begin
        if (phase_r == P_DIV && !div_done && i_r != CW'(ORDER - 1) && j_r == '1) begin
          state_nxt = S_B_RD;
        end
        mem_ra    = addr(i_r, i_r);
        state_nxt = S_B_CHK;
      end
      S_B_CHK: begin
        piv_nxt = rd_data_r;
        sum_nxt = '0;
        // aij_r marks a started divide in S_B_YRD, so it starts out clear.
        aij_nxt = 32'sd0;
        if (rd_data_r == 32'sd0) begin
          sing_nxt  = 1'b1;
          i_nxt     = '0;
          mem_ra    = addr('0, CW'(ORDER));
          phase_nxt = P_OUT;
          state_nxt = S_LOAD;
        end else if (i_r == CW'(ORDER - 1)) begin
          state_nxt = S_B_YRD;
        end else begin
          j_nxt     = i_r + 1'b1;
          state_nxt = S_B_JRD;
        end
      end
      S_B_JRD: begin
        mem_ra    = addr(i_r, j_r);
        state_nxt = S_B_MUL;
      end
      S_B_MUL: begin
        prod_nxt  = 64'(rd_data_r) * 64'(x_r[j_r[XW-1:0]]);
        state_nxt = S_B_ACC;
      end
      S_B_ACC: begin
        sum_nxt = sum_r + 53'(prod_r >>> FRAC_BITS);
        if (j_r == CW'(ORDER - 1)) begin
          state_nxt = S_B_YRD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_B_JRD;
        end
      end
      S_B_YRD: begin
        // Issue the y read, then start the divide, then wait for its done.
        if (j_r != '1) begin
          mem_ra    = addr(i_r, CW'(ORDER));
          j_nxt     = '1;
        end else if (!div_start && phase_r == P_DIV && aij_r != 32'sd1) begin
          div_start = 1'b1;
          div_num   = sat32(64'(rd_data_r) - 64'(sum_r));
          aij_nxt   = 32'sd1;
        end else if (div_done) begin
          x_we    = 1'b1;
          aij_nxt = 32'sd0;
          j_nxt   = '0;
          if (i_r == '0) begin
            mem_ra    = addr('0, CW'(ORDER));
            phase_nxt = P_OUT;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_B_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
        phase_nxt = P_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_r[i_r[XW-1:0]] <= div_quot;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    piv_r  <= piv_nxt;
    m_r    <= m_nxt;
    akj_r  <= akj_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    if (!rst_n) begin
      state_r <= S_LOAD;
      phase_r <= P_NONE;
      lcnt_r  <= '0;
      sing_r  <= 1'b0;
      j_r     <= '0;
      aij_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      lcnt_r  <= lcnt_nxt;
      sing_r  <= sing_nxt;
      j_r     <= j_nxt;
      aij_r   <= aij_nxt;
    end
  end

  // A singular system reports zero values on every result word.
  assign out_row_index          = 3'(i_r);
  assign out_singular_flag      = sing_r;
  assign out_solution_value     = sing_r ? 32'sd0 : x_r[i_r[XW-1:0]];
  assign out_intermediate_value = sing_r ? 32'sd0 : rd_data_r;
  assign out_last_result        = (i_r == CW'(ORDER - 1));

  `LU_ASSERT_NOW(a_busy_while_out, clk, rst_n, out_valid, in_stall,
    "input accepted while results pending")
  `LU_ASSERT_NOW(a_sing_zero, clk, rst_n, out_valid && out_singular_flag,
    out_solution_value == 32'sd0 && out_intermediate_value == 32'sd0,
    "singular result carries nonzero values")
  `LU_ASSERT_NEXT(a_last_frees, clk, rst_n, out_go && out_last_result,
    !in_stall && !out_valid, "block not ready after final result")
endmodule
`default_nettype wire

// ===== hdl/lu_div.sv =====
// Radix-2 restoring divider for Q16.16 quotients, one quotient bit per cycle.
`default_nettype none
module lu_div import lu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic                    done,
  output logic signed [31:0]      quot
);
  logic [QUOT_BITS-1:0] n_r, n_nxt;
  logic [32:0]          rem_r, rem_nxt;
  logic [31:0]          den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [32:0]          trial;
  logic [QUOT_BITS:0]   mag;

  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], n_r[QUOT_BITS-1]};
    if (start) begin
      // The numerator is scaled by 2^16, so its magnitude fits in 48 bits.
      n_nxt    = {(num[31] ? 32'(-num) : 32'(num)), 16'h0000};
      den_nxt  = den[31] ? 32'(-den) : 32'(den);
      neg_nxt  = num[31] ^ den[31];
      rem_nxt  = '0;
      cnt_nxt  = 6'(QUOT_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        n_nxt   = {n_r[QUOT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        n_nxt   = {n_r[QUOT_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Apply the sign and saturate to the Q16.16 range.
  always_comb begin
    mag = {1'b0, n_r};
    if (neg_r) begin
      quot = (mag > (QUOT_BITS+1)'(33'h1_0000_0000 >> 1)) ? Q_MIN : 32'(-mag);
    end else begin
      quot = (mag > (QUOT_BITS+1)'(Q_MAX)) ? Q_MAX : mag[31:0];
    end
  end

  assign done = done_r;
endmodule
`default_nettype wire
